>>> src/fsbc32_pkg.sv
// ----------------------------------------------------------------------------
// fsbc32_pkg
// shared constants, types and round function of the 32-bit feistel cipher core
// ----------------------------------------------------------------------------
package fsbc32_pkg;

    localparam int MAX_ROUNDS = 32;
    // key table index width, at least one bit
    localparam int KI_W       = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
    // round counter width, holds MAX_ROUNDS itself
    localparam int RC_W       = $clog2(MAX_ROUNDS + 1);

    localparam int ACTION_W   = 2;
    localparam int KEY_IDX_W  = 5;
    localparam int KEY_W      = 16;
    localparam int HALF_W     = 16;
    localparam int BLOCK_W    = 2 * HALF_W;
    localparam int ROUNDS_W   = 6;
    // tdata packing: key_index, key_value, data_block, zero fill to bytes
    localparam int IN_FIELDS_W = KEY_IDX_W + KEY_W + BLOCK_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int KV_LSB      = KEY_IDX_W;
    localparam int BLK_LSB     = KEY_IDX_W + KEY_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_KEY = 2'd0,
        ACT_ENCRYPT  = 2'd1,
        ACT_DECRYPT  = 2'd2
    } t_action;

    localparam logic [3:0] SBOX [16] = '{
        4'd12, 4'd5, 4'd6, 4'd11, 4'd9, 4'd0, 4'd10, 4'd13,
        4'd3, 4'd14, 4'd15, 4'd8, 4'd4, 4'd7, 4'd1, 4'd2
    };

    localparam logic [3:0] PERM [16] = '{
        4'd7, 4'd13, 4'd1, 4'd8, 4'd11, 4'd14, 4'd2, 4'd5,
        4'd4, 4'd10, 4'd15, 4'd0, 4'd3, 4'd6, 4'd9, 4'd12
    };

    // controller to datapath commands
    typedef struct packed {
        logic            blk_load;
        logic            round_en;
        logic            decrypt;
        logic            key_we;
        logic [KI_W-1:0] key_idx;
        logic            out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // substitute nibbles then permute bits
    function automatic logic [HALF_W-1:0] round_func(input logic [HALF_W-1:0] v);
        logic [HALF_W-1:0] sub;
        logic [HALF_W-1:0] res;
        sub = '0;
        res = '0;
        for (int i = 0; i < HALF_W / 4; i++) begin
            sub[4*i +: 4] = SBOX[v[4*i +: 4]];
        end
        for (int i = 0; i < HALF_W; i++) begin
            res[PERM[i]] = sub[i];
        end
        return res;
    endfunction

endpackage

>>> src/fsbc32_dp.sv
// ----------------------------------------------------------------------------
// fsbc32_dp
// round key table, half registers, shared round unit and output register
// ----------------------------------------------------------------------------
module fsbc32_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fsbc32_pkg::t_dp_cmd          i_cmd,
    output fsbc32_pkg::t_dp_status       o_status,
    input  logic [fsbc32_pkg::KEY_W-1:0]   i_key_value,
    input  logic [fsbc32_pkg::BLOCK_W-1:0] i_data_block,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [fsbc32_pkg::BLOCK_W-1:0] o_out_data
);
    import fsbc32_pkg::*;

    logic [KEY_W-1:0]   r_keys [MAX_ROUNDS];
    logic [HALF_W-1:0]  r_left;
    logic [HALF_W-1:0]  r_right;
    logic [BLOCK_W-1:0] r_out_data;
    logic               r_out_valid;

    logic [HALF_W-1:0]  n_left;
    logic [HALF_W-1:0]  n_right;
    logic [HALF_W-1:0]  f_in;
    logic [HALF_W-1:0]  f_out;
    logic [KEY_W-1:0]   cur_key;

    assign cur_key = r_keys[i_cmd.key_idx];
    // decrypt feeds the left half through f, encrypt the right half
    assign f_in      = (i_cmd.decrypt ? r_left : r_right) ^ cur_key;
    assign f_out     = round_func(f_in);

    always_comb begin
        n_left  = r_left;
        n_right = r_right;
        if (i_cmd.blk_load) begin
            n_left  = i_data_block[BLOCK_W-1:HALF_W];
            n_right = i_data_block[HALF_W-1:0];
        end else if (i_cmd.round_en) begin
            if (i_cmd.decrypt) begin
                n_left  = r_right ^ f_out;
                n_right = r_left;
            end else begin
                n_left  = r_right;
                n_right = r_left ^ f_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_right <= n_right;
        if (i_cmd.key_we) begin
            r_keys[i_cmd.key_idx] <= i_key_value;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {r_left, r_right};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

>>> src/fsbc32_ctrl.sv
// ----------------------------------------------------------------------------
// fsbc32_ctrl
// round sequencer and round count register
// ----------------------------------------------------------------------------
module fsbc32_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [fsbc32_pkg::ACTION_W-1:0]   i_action,
    input  logic [fsbc32_pkg::KEY_IDX_W-1:0]  i_key_index,
    input  logic                              i_cfg_valid,
    input  logic [fsbc32_pkg::ROUNDS_W-1:0]   i_cfg_data,
    output fsbc32_pkg::t_dp_cmd               o_cmd,
    input  fsbc32_pkg::t_dp_status            i_status
);
    import fsbc32_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [ROUNDS_W-1:0] r_round_count;
    logic [RC_W-1:0]     r_remain, n_remain;
    logic [KI_W-1:0]     r_kidx, n_kidx;
    logic                r_dec, n_dec;

    logic                        accept;
    logic [ROUNDS_W:0]           rc_ext;
    logic [RC_W-1:0]             active_n;
    logic [KEY_IDX_W+KI_W-1:0]   kidx_ext;
    logic                        kidx_ok;

    assign accept   = i_in_valid && o_in_ready;
    assign rc_ext   = {1'b0, r_round_count};
    // saturate at the table depth
    assign active_n = (rc_ext > (ROUNDS_W+1)'(MAX_ROUNDS)) ? RC_W'(MAX_ROUNDS)
                                                           : RC_W'(rc_ext);
    assign kidx_ext = {{KI_W{1'b0}}, i_key_index};
    assign kidx_ok  = kidx_ext < (KEY_IDX_W+KI_W)'(MAX_ROUNDS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_count <= ROUNDS_W'(32);
        end else if (i_cfg_valid) begin
            r_round_count <= i_cfg_data;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_remain = r_remain;
        n_kidx   = r_kidx;
        n_dec    = r_dec;
        o_cmd    = '0;
        o_cmd.decrypt = r_dec;
        o_cmd.key_idx = r_kidx;
        o_in_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    case (i_action)
                        ACT_LOAD_KEY: begin
                            o_cmd.key_we  = kidx_ok;
                            o_cmd.key_idx = kidx_ext[KI_W-1:0];
                        end
                        ACT_ENCRYPT, ACT_DECRYPT: begin
                            o_cmd.blk_load = 1'b1;
                            n_dec    = (i_action == ACT_DECRYPT);
                            n_remain = active_n;
                            n_kidx   = (i_action == ACT_DECRYPT) ? KI_W'(active_n - 1'b1)
                                                                 : '0;
                            n_state  = (active_n == '0) ? S_DONE : S_RUN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                o_cmd.round_en = 1'b1;
                n_remain = r_remain - 1'b1;
                n_kidx   = r_dec ? (r_kidx - 1'b1) : (r_kidx + 1'b1);
                if (r_remain == RC_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_remain <= '0;
            r_kidx   <= '0;
            r_dec    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_remain <= n_remain;
            r_kidx   <= n_kidx;
            r_dec    <= n_dec;
        end
    end

endmodule

>>> src/feistel_spn_block_cipher_32_core.sv
// ----------------------------------------------------------------------------
// feistel_spn_block_cipher_32_core
// 32-bit feistel cipher with 16-bit halves, one shared round unit
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     contents
//  s_axis    in         s_axis_tvalid/s_axis_tready   action, key_index, key_value, block
//  m_axis    out        m_axis_tvalid/m_axis_tready   result_block
//  cfg       in         i_cfg_valid/o_cfg_ready       round_count
//
//  a block is loaded on transfer and runs n rounds, n the round count saturated at
//  MAX_ROUNDS, then is handed off to the output register; input is ready again the
//  cycle after, so a block in flight holds off new input; key loads write on transfer
//  reset clears the sequencer and output valid and sets round_count to 32, not keys
//  a stalled result holds the output register; the sequencer waits before handoff
//  while that register is full and m_axis_tready is low
// ----------------------------------------------------------------------------
module feistel_spn_block_cipher_32_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // slave side
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // key_index [4:0], key_value [20:5], data_block [52:21], zero fill
    input  logic [fsbc32_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // action [1:0]
    input  logic [fsbc32_pkg::ACTION_W-1:0]        s_axis_tuser,
    // master side
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // result_block [31:0]
    output logic [fsbc32_pkg::BLOCK_W-1:0]         m_axis_tdata,
    // configuration write
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [fsbc32_pkg::ROUNDS_W-1:0]        i_cfg_data
);
    import fsbc32_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // unpack the input transfer
    logic [KEY_IDX_W-1:0] in_key_index;
    logic [KEY_W-1:0]     in_key_value;
    logic [BLOCK_W-1:0]   in_data_block;

    assign in_key_index  = s_axis_tdata[KEY_IDX_W-1:0];
    assign in_key_value  = s_axis_tdata[KV_LSB +: KEY_W];
    assign in_data_block = s_axis_tdata[BLK_LSB +: BLOCK_W];

    // register writes must come only while idle; the block does not enforce this and always takes them
    assign o_cfg_ready = 1'b1;

    fsbc32_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_key_index (in_key_index),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    fsbc32_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_key_value  (in_key_value),
        .i_data_block (in_data_block),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata)
    );

endmodule

>>> tb/tb_feistel_spn_block_cipher_32_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_feistel_spn_block_cipher_32_core
// self-checking bench for the 32-bit feistel cipher core: fills the key table,
// runs directed corner blocks, then random key loads, encrypts, decrypts and
// round trips under several round counts, including zero and saturated
// counts. Results are checked in order against a bit-accurate predictor.
// ----------------------------------------------------------------------------
module tb_feistel_spn_block_cipher_32_core;

    import fsbc32_pkg::*;

    // action code with no function, the core drops it
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 500000;
    // load cycle, rounds, handoff, plus margin
    localparam int TAIL_CYCLES  = MAX_ROUNDS + 8;
    localparam int PHASE_ITEMS  = 225;
    localparam int NUM_PHASES   = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 100;

    // ------------------------------------------------------------------------
    // cipher predictor and in-order result store
    // ------------------------------------------------------------------------
    class cipher_scoreboard;
        logic [KEY_W-1:0]   key_table [MAX_ROUNDS];
        logic [ROUNDS_W-1:0] round_setting;
        logic [BLOCK_W-1:0] queued_blocks [$];
        int mismatch_count;
        int results_checked;
        int n_encrypt;
        int n_decrypt;
        int n_key_load;
        int n_dropped;

        function new();
            round_setting   = 6'd32;
            mismatch_count  = 0;
            results_checked = 0;
            n_encrypt       = 0;
            n_decrypt       = 0;
            n_key_load      = 0;
            n_dropped       = 0;
            for (int i = 0; i < MAX_ROUNDS; i++) key_table[i] = '0;
        endfunction

        function void set_rounds(logic [ROUNDS_W-1:0] v);
            round_setting = v;
        endfunction

        function int pending();
            return queued_blocks.size();
        endfunction

        // nibble substitution then bit scatter of (v ^ k)
        function logic [HALF_W-1:0] mix_half(logic [HALF_W-1:0] v, logic [KEY_W-1:0] k);
            logic [63:0]       sub_tab;
            logic [63:0]       dest_tab;
            logic [HALF_W-1:0] x;
            logic [HALF_W-1:0] s;
            logic [HALF_W-1:0] p;
            sub_tab  = 64'h2174_8fe3_da09_b65c;
            dest_tab = 64'hc963_0fa4_52eb_81d7;
            x = v ^ k;
            s = '0;
            p = '0;
            for (int i = 0; i < 4; i++) s[4*i +: 4] = sub_tab[4*x[4*i +: 4] +: 4];
            for (int i = 0; i < HALF_W; i++) p[dest_tab[4*i +: 4]] = s[i];
            return p;
        endfunction

        // note one accepted input, returns the predicted block if any
        function logic [BLOCK_W-1:0] note_input(logic [ACTION_W-1:0] act,
                                                logic [KEY_IDX_W-1:0] kidx,
                                                logic [KEY_W-1:0] kval,
                                                logic [BLOCK_W-1:0] blk);
            int                n;
            logic [HALF_W-1:0] lh;
            logic [HALF_W-1:0] rh;
            logic [HALF_W-1:0] t;
            n  = (round_setting > MAX_ROUNDS) ? MAX_ROUNDS : int'(round_setting);
            lh = blk[BLOCK_W-1 -: HALF_W];
            rh = blk[HALF_W-1:0];
            if (act == ACT_LOAD_KEY) begin
                if (kidx < MAX_ROUNDS) key_table[kidx] = kval;
                n_key_load++;
                return '0;
            end else if (act == ACT_ENCRYPT) begin
                for (int r = 0; r < n; r++) begin
                    t  = lh ^ mix_half(rh, key_table[r]);
                    lh = rh;
                    rh = t;
                end
                n_encrypt++;
            end else if (act == ACT_DECRYPT) begin
                for (int r = n; r > 0; r--) begin
                    t  = rh ^ mix_half(lh, key_table[r-1]);
                    rh = lh;
                    lh = t;
                end
                n_decrypt++;
            end else begin
                n_dropped++;
                return '0;
            end
            queued_blocks.push_back({lh, rh});
            return {lh, rh};
        endfunction

        function void check_result(logic [BLOCK_W-1:0] got);
            logic [BLOCK_W-1:0] want;
            if (queued_blocks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result %08h, nothing outstanding", $time, got);
                return;
            end
            want = queued_blocks.pop_front();
            results_checked++;
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result_block mismatch, expected %08h actual %08h",
                             $time, want, got);
            end
        endfunction

        function void flag_leftovers();
            while (queued_blocks.size() != 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result never came, expected %08h actual none",
                             $time, queued_blocks[0]);
                void'(queued_blocks.pop_front());
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // key_index [4:0], key_value [20:5], data_block [52:21], zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // action [1:0]
    logic [ACTION_W-1:0]    s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // result_block [31:0]
    logic [BLOCK_W-1:0]     m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [ROUNDS_W-1:0]    i_cfg_data = '0;

    cipher_scoreboard sb;

    // random idling switches for each side, cleared for one middle phase and the closing phase
    bit  src_idle_on  = 1'b1;
    bit  sink_idle_on = 1'b1;
    // long receiver hold-off requested by the stimulus, consumed by the sink
    int  hold_request = 0;
    int  cycle_count  = 0;
    logic [BLOCK_W-1:0] last_cipher = '0;

    always #5 i_clk = ~i_clk;

    feistel_spn_block_cipher_32_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("tb_feistel_spn_block_cipher_32_core: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result side: checks every transfer, stalls in short random bursts or
    // for one long stretch on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_axis_tready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                // start a stall burst of random length, this stall included
                gap_left = int'($urandom_range(1, 3)) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side tasks, all entered and left right after a rising edge
    // ------------------------------------------------------------------------

    // offer one item and hold it until the transfer, then predict its result
    task automatic push_item(input logic [ACTION_W-1:0]  act,
                             input logic [KEY_IDX_W-1:0] kidx,
                             input logic [KEY_W-1:0]     kval,
                             input logic [BLOCK_W-1:0]   blk);
        logic [IN_TDATA_W-1:0] word;
        logic [BLOCK_W-1:0]    predicted;
        word = '0;
        word[KEY_IDX_W-1:0]      = kidx;
        word[KV_LSB +: KEY_W]    = kval;
        word[BLK_LSB +: BLOCK_W] = blk;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = sb.note_input(act, kidx, kval, blk);
        if (act == ACT_ENCRYPT) last_cipher = predicted;
    endtask

    task automatic pause_source(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // sender stops until every predicted result has been seen, then waits
    // out a quiet tail before going on
    task automatic drain_core();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // round_count write, only with the core idle
    task automatic write_rounds(input logic [ROUNDS_W-1:0] v);
        drain_core();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_rounds(v);
    endtask

    // one random item, mostly blocks with some key reloads and dropped codes;
    // returns 0 when the item is one the core merely drops
    task automatic random_item(output bit counted);
        int unsigned pick;
        logic [BLOCK_W-1:0] blk;
        pick = $urandom_range(0, 99);
        blk  = $urandom;
        // corner blocks now and then
        if ($urandom_range(0, 15) == 0) blk = $urandom_range(0, 1) ? '1 : '0;
        if (src_idle_on && $urandom_range(0, 3) == 0) pause_source(int'($urandom_range(1, 3)));
        counted = 1'b1;
        if (pick < 12) begin
            push_item(ACT_LOAD_KEY, KEY_IDX_W'($urandom_range(0, 31)), KEY_W'($urandom),
                      BLOCK_W'($urandom));
        end else if (pick < 16) begin
            push_item(ACT_UNUSED, KEY_IDX_W'($urandom_range(0, 31)), KEY_W'($urandom),
                      BLOCK_W'($urandom));
            counted = 1'b0;
        end else if (pick < 58) begin
            push_item(ACT_ENCRYPT, KEY_IDX_W'($urandom_range(0, 31)), KEY_W'($urandom), blk);
        end else if (pick < 80) begin
            push_item(ACT_DECRYPT, KEY_IDX_W'($urandom_range(0, 31)), KEY_W'($urandom), blk);
        end else begin
            // round trip of the last ciphertext
            push_item(ACT_DECRYPT, KEY_IDX_W'($urandom_range(0, 31)), KEY_W'($urandom),
                      last_cipher);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [ROUNDS_W-1:0] setting;
        int                  done_items;
        bit                  counted;
        logic [BLOCK_W-1:0]  ct;

        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole key table first, no round may read an unwritten key
        for (int i = 0; i < MAX_ROUNDS; i++) begin
            if (i == 0)
                push_item(ACT_LOAD_KEY, KEY_IDX_W'(i), 16'h0000, BLOCK_W'($urandom));
            else if (i == MAX_ROUNDS - 1)
                push_item(ACT_LOAD_KEY, KEY_IDX_W'(i), 16'hffff, BLOCK_W'($urandom));
            else
                push_item(ACT_LOAD_KEY, KEY_IDX_W'(i), KEY_W'($urandom), BLOCK_W'($urandom));
        end

        // directed corners at the reset round count of 32
        push_item(ACT_ENCRYPT, '0, '0, 32'h0000_0000);
        push_item(ACT_ENCRYPT, '1, '1, 32'hffff_ffff);
        push_item(ACT_DECRYPT, '0, '0, 32'h0000_0000);
        push_item(ACT_DECRYPT, '1, '1, 32'hffff_ffff);
        push_item(ACT_ENCRYPT, '0, '0, 32'h0000_ffff);
        push_item(ACT_ENCRYPT, '0, '0, 32'hffff_0000);
        push_item(ACT_ENCRYPT, '0, '0, 32'haaaa_5555);
        ct = last_cipher;
        // decrypt must undo the encrypt
        push_item(ACT_DECRYPT, '0, '0, ct);
        // unused action with every field bit set, core must drop it
        push_item(ACT_UNUSED, '1, '1, '1);
        // swap the edge keys and run again
        push_item(ACT_LOAD_KEY, 5'd31, 16'h0000, '0);
        push_item(ACT_LOAD_KEY, 5'd0, 16'hffff, '0);
        push_item(ACT_ENCRYPT, '0, '0, 32'h1234_5678);
        push_item(ACT_DECRYPT, '0, '0, last_cipher);

        // random phases over several round counts: zero rounds passes the
        // block through, counts past 32 saturate
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: setting = 6'd0;
                1: setting = 6'd1;
                2: setting = 6'd63;
                3: setting = 6'd33;
                4: setting = 6'd31;
                5: setting = 6'd2;
                6: setting = 6'($urandom_range(3, 30));
                default: setting = 6'd32;
            endcase
            // a phase with no idling in the middle, and none at the end
            src_idle_on  = (p != 3) && (p != NUM_PHASES - 1);
            sink_idle_on = src_idle_on;
            write_rounds(setting);
            done_items = 0;
            while (done_items < PHASE_ITEMS) begin
                // long receiver stall while items keep coming, fills the core
                if (p == 1 && done_items == 40) hold_request = HOLD_CYCLES;
                // sender waits for every outstanding result mid-phase
                if (p == 4 && done_items == 100) drain_core();
                random_item(counted);
                if (counted) done_items++;
            end
        end

        // wind down: let every outstanding result arrive, then a quiet tail
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.flag_leftovers();

        $display("run covered %0d encrypts, %0d decrypts, %0d key loads, %0d dropped codes",
                 sb.n_encrypt, sb.n_decrypt, sb.n_key_load, sb.n_dropped);
        $display("%0d results checked over round counts 32, 0, 1, 63, 33, 31, 2, mid, %0d mismatches",
                 sb.results_checked, sb.mismatch_count);
        if (sb.mismatch_count == 0) begin
            $display("tb_feistel_spn_block_cipher_32_core: clean");
        end else begin
            $display("tb_feistel_spn_block_cipher_32_core: errors");
        end
        $finish;
    end

endmodule
